[src/lru_pkg.sv]
// Shared types and constants for the LRU key-value store.
package lru_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int CAP_WIDTH       = 5;
    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 5'd16;
    localparam logic signed [31:0] READ_MISS = -32'sd1;

    typedef enum logic {
        MODE_GET = 1'b0,
        MODE_SET = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    // Scalar results of one pass over the entry array.
    typedef struct packed {
        logic        hit;
        logic        evict;
        logic        slot_found;
        logic [31:0] hit_value;
        logic [31:0] lru_key;
    } lookup_t;

endpackage

[src/lru_lookup.sv]
// Parallel key match, LRU pick and free slot search over all entries.
module lru_lookup
    import lru_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES,
    parameter int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int OW      = $clog2(ENTRIES + 1)
)
(
    input  logic [31:0]        key,
    input  logic               is_set,
    input  logic               full,
    input  logic [OW-1:0]      occupancy,
    input  logic [31:0]        keys [ENTRIES],
    input  logic [31:0]        values [ENTRIES],
    input  logic [RW-1:0]      ranks [ENTRIES],
    input  logic [ENTRIES-1:0] valid,
    output logic [ENTRIES-1:0] match,
    output logic [ENTRIES-1:0] free_vec,
    output logic [ENTRIES-1:0] valid_kept,
    output logic [RW-1:0]      hit_rank,
    output lookup_t            result
);

    logic [ENTRIES-1:0] lru_vec;
    logic [RW-1:0]      lru_rank;
    logic [31:0]        hit_value;
    logic [31:0]        lru_key;
    logic               evict;

    // Valid ranks are always 0 .. occupancy-1, so the oldest holds occupancy-1.
    assign lru_rank = RW'(occupancy - OW'(1));

    always_comb
    begin
        hit_value = '0;
        lru_key   = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]   = valid[i] && (keys[i] == key);
            lru_vec[i] = valid[i] && (ranks[i] == lru_rank);
            if (match[i])
            begin
                hit_value = hit_value | values[i];
                hit_rank  = hit_rank | ranks[i];
            end
            if (lru_vec[i])
            begin
                lru_key = lru_key | keys[i];
            end
        end
    end

    assign evict      = is_set && !(|match) && full && (|lru_vec);
    assign valid_kept = evict ? (valid & ~lru_vec) : valid;
    // Lowest clear bit of the surviving valid mask.
    assign free_vec   = ~valid_kept & (valid_kept + ENTRIES'(1));

    assign result.hit        = |match;
    assign result.evict      = evict;
    assign result.slot_found = |free_vec;
    assign result.hit_value  = hit_value;
    assign result.lru_key    = lru_key;

endmodule

[src/lru_cache_key_value_store.sv]
// Top level of the fully associative LRU key-value store.
//
//   port group   dir   handshake          word
//   req          in    req_valid/stall    req_t: mode, key, value
//   rsp          out   rsp_valid/stall    rsp_t: hit, read_value, evicted, evicted_key
//   cfg          in    cfg_valid/ready    capacity, 5 bits
//
// One operation per cycle while the response is not stalled: a word is held in the
// request register, then the combinational compare and rank update over all entries
// loads the response register.
// Reset clears the valid bits, ranks and occupancy at once; no clearing pass follows.
// A stalled response holds the pipe; the request register still takes a word if it
// is empty or drains in the same cycle.
module lru_cache_key_value_store
    import lru_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_WIDTH-1:0] cfg_data
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    logic [CAP_WIDTH-1:0] capacity_reg;
    logic                 req_valid_reg;
    req_t                 req_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [31:0]          key_reg [ENTRIES];
    logic [31:0]          value_reg [ENTRIES];
    logic [RW-1:0]        rank_reg [ENTRIES];
    logic [RW-1:0]        rank_next [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [OW-1:0]        occupancy_reg;
    logic [OW-1:0]        occupancy_next;
    logic [OW-1:0]        eff_capacity;
    logic [8:0]           cap_wide;

    logic                 advance;
    logic                 is_set;
    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   valid_kept;
    logic [RW-1:0]        hit_rank;
    lookup_t              lookup;

    assign cfg_ready = 1'b1;
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;
    assign is_set    = (req_reg.mode == MODE_SET);

    // Capacity zero acts as one, and values above the entry count saturate.
    assign cap_wide = {4'b0, capacity_reg};
    always_comb
    begin
        if (capacity_reg == '0)
            eff_capacity = OW'(1);
        else if (cap_wide > 9'(ENTRIES))
            eff_capacity = OW'(ENTRIES);
        else
            eff_capacity = OW'(capacity_reg);
    end

    lru_lookup #(
        .ENTRIES (ENTRIES),
        .RW      (RW),
        .OW      (OW)
    ) u_lookup (
        .key        (req_reg.key),
        .is_set     (is_set),
        .full       (occupancy_reg >= eff_capacity),
        .occupancy  (occupancy_reg),
        .keys       (key_reg),
        .values     (value_reg),
        .ranks      (rank_reg),
        .valid      (valid_reg),
        .match      (match),
        .free_vec   (free_vec),
        .valid_kept (valid_kept),
        .hit_rank   (hit_rank),
        .result     (lookup)
    );

    always_comb
    begin
        valid_next     = valid_reg;
        occupancy_next = occupancy_reg;
        rank_next      = rank_reg;
        rsp_next.hit         = lookup.hit;
        rsp_next.evicted     = lookup.evict;
        rsp_next.evicted_key = lookup.evict ? lookup.lru_key : '0;
        if (!is_set)
            rsp_next.read_value = lookup.hit ? lookup.hit_value : READ_MISS;
        else
            rsp_next.read_value = '0;

        if (lookup.hit)
        begin
            // Entries more recent than the hit one age by one.
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
        end
        else if (is_set)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (free_vec[i])
                    rank_next[i] = '0;
                else if (valid_kept[i])
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
            valid_next     = valid_kept | free_vec;
            occupancy_next = occupancy_reg - OW'(lookup.evict) + OW'(lookup.slot_found);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occupancy_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            if (!req_stall)
                req_valid_reg <= req_valid;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                valid_reg     <= valid_next;
                occupancy_reg <= occupancy_next;
                rank_reg      <= rank_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            req_reg <= req_word;
        if (advance)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (is_set && (match[i] || (!lookup.hit && free_vec[i])))
                    value_reg[i] <= req_reg.value;
                if (is_set && !lookup.hit && free_vec[i])
                    key_reg[i] <= req_reg.key;
            end
        end
    end

    // The valid mask and the fill count must never drift apart.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occupancy_reg))
    else $error("valid mask and occupancy disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(occupancy_reg) <= ENTRIES)
    else $error("occupancy above entry count");

    // Only a set of an absent key can evict.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.evicted |-> !rsp_reg.hit && rsp_reg.read_value == '0)
    else $error("eviction reported with a hit or a read value");

    // A key is held in at most one valid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> $onehot0(match))
    else $error("key matched in more than one entry");

endmodule

[tb/sv/tb_lru_cache_key_value_store.sv]
// Self-checking testbench for the LRU key-value store: directed and random get/set traffic.
module tb_lru_cache_key_value_store;
    import lru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = DEFAULT_ENTRIES;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 75;
    localparam int DRAIN_CYCLES   = 10;

    // Tracks the cache contents and the queue of responses still owed by the block.
    class lru_scoreboard;
        logic [31:0]          keys  [SLOTS];
        logic [31:0]          vals  [SLOTS];
        bit                   live  [SLOTS];
        bit [3:0]             ranks [SLOTS];
        int unsigned          fill;
        logic [CAP_WIDTH-1:0] cap_reg;
        rsp_t                 owed_q[$];
        int unsigned          failures;

        function new();
            foreach (live[i])
            begin
                live[i]  = 1'b0;
                ranks[i] = '0;
                keys[i]  = '0;
                vals[i]  = '0;
            end
            fill     = 0;
            cap_reg  = CAPACITY_RESET;
            failures = 0;
        endfunction

        function void set_capacity(logic [CAP_WIDTH-1:0] c);
            cap_reg = c;
        endfunction

        // Zero behaves as one, anything above the array size saturates.
        function int unsigned effective_capacity();
            int unsigned c;
            c = cap_reg;
            if (c < 1)
                c = 1;
            if (c > SLOTS)
                c = SLOTS;
            return c;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void note_request(req_t r);
            rsp_t        exp;
            int          found;
            int          victim;
            int          slot;
            bit [3:0]    old_rank;
            exp   = '0;
            found = -1;
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && live[i] && keys[i] == r.key)
                    found = i;
            if (found >= 0)
            begin
                exp.hit  = 1'b1;
                old_rank = ranks[found];
                for (int i = 0; i < SLOTS; i++)
                    if (live[i] && ranks[i] < old_rank)
                        ranks[i]++;
                ranks[found] = '0;
                if (r.mode == MODE_GET)
                    exp.read_value = vals[found];
                else
                    vals[found] = r.value;
            end
            else if (r.mode == MODE_GET)
            begin
                exp.read_value = READ_MISS;
            end
            else
            begin
                if (fill >= effective_capacity())
                begin
                    victim = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i] && (victim < 0 || ranks[i] > ranks[victim]))
                            victim = i;
                    if (victim >= 0)
                    begin
                        exp.evicted     = 1'b1;
                        exp.evicted_key = keys[victim];
                        live[victim]    = 1'b0;
                        fill--;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    if (live[i])
                        ranks[i]++;
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !live[i])
                        slot = i;
                if (slot >= 0)
                begin
                    live[slot]  = 1'b1;
                    keys[slot]  = r.key;
                    vals[slot]  = r.value;
                    ranks[slot] = '0;
                    fill++;
                end
            end
            owed_q.push_back(exp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected response word: hit=%0d read_value=%0d evicted=%0d key=%0d",
                         $time, got.hit, got.read_value, got.evicted, got.evicted_key);
                failures++;
                return;
            end
            exp = owed_q.pop_front();
            if (got.hit !== exp.hit)
            begin
                $display("%0t: hit mismatch: expected %0d, actual %0d", $time, exp.hit, got.hit);
                failures++;
            end
            if (got.read_value !== exp.read_value)
            begin
                $display("%0t: read_value mismatch: expected %0d, actual %0d",
                         $time, exp.read_value, got.read_value);
                failures++;
            end
            if (got.evicted !== exp.evicted)
            begin
                $display("%0t: evicted mismatch: expected %0d, actual %0d",
                         $time, exp.evicted, got.evicted);
                failures++;
            end
            if (got.evicted_key !== exp.evicted_key)
            begin
                $display("%0t: evicted_key mismatch: expected %0d, actual %0d",
                         $time, exp.evicted_key, got.evicted_key);
                failures++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_WIDTH-1:0] cfg_data  = '0;

    lru_scoreboard board = new();

    // Written only by the stimulus process.
    bit steady    = 1'b0;
    bit want_hold = 1'b0;

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;

    lru_cache_key_value_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Response side: check every accepted word, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp_word);
            if (want_hold && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= !steady && ($urandom_range(0, 99) < 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_lru_cache_key_value_store failed");
                $finish;
            end
        end
    end

    function automatic req_t make_req(mode_t m, logic [31:0] k, logic [31:0] v);
        req_t r;
        r.mode  = m;
        r.key   = k;
        r.value = v;
        return r;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Mostly keys from a small window so gets hit and sets update or evict.
    function automatic req_t random_req(int unsigned pool, logic [31:0] base);
        req_t        r;
        int unsigned pick;
        pick    = $urandom_range(0, 99);
        r.mode  = ($urandom_range(0, 1) != 0) ? MODE_SET : MODE_GET;
        if (pick < 85)
            r.key = base + $urandom_range(0, pool - 1);
        else if (pick < 95)
            r.key = $urandom;
        else
            r.key = extreme_word();
        r.value = ($urandom_range(0, 9) == 0) ? extreme_word() : $urandom;
        return r;
    endfunction

    task automatic send_req(input req_t r);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] c);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_capacity(c);
    endtask

    initial
    begin
        logic [CAP_WIDTH-1:0] caps [10];
        logic [31:0]          base;
        int unsigned          pool;

        caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd8, 5'd0, 5'd16, 5'd2, 5'd20, 5'd12};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill, hit, miss and update at the extremes of key and value.
        write_capacity(5'd16);
        send_req(make_req(MODE_GET, 32'h0000_0000, 32'h0000_0000));
        send_req(make_req(MODE_SET, 32'h8000_0000, 32'h7fff_ffff));
        send_req(make_req(MODE_SET, 32'h7fff_ffff, 32'h8000_0000));
        send_req(make_req(MODE_SET, 32'hffff_ffff, 32'hffff_ffff));
        send_req(make_req(MODE_SET, 32'h0000_0000, 32'h0000_0000));
        send_req(make_req(MODE_GET, 32'h8000_0000, 32'h1234_5678));
        send_req(make_req(MODE_GET, 32'd12345, 32'h0000_0000));
        send_req(make_req(MODE_SET, 32'h7fff_ffff, 32'd7));
        send_req(make_req(MODE_GET, 32'h7fff_ffff, 32'h0000_0000));
        send_req(make_req(MODE_GET, 32'hffff_ffff, 32'hffff_ffff));

        // Capacity dropped below the occupancy: each new key evicts exactly one.
        write_capacity(5'd2);
        send_req(make_req(MODE_SET, 32'd100, 32'd1));
        send_req(make_req(MODE_SET, 32'd101, 32'd2));
        send_req(make_req(MODE_GET, 32'd100, 32'd0));
        send_req(make_req(MODE_GET, 32'h0000_0000, 32'd0));

        // A capacity of zero acts as one.
        write_capacity(5'd0);
        send_req(make_req(MODE_SET, 32'd200, 32'd3));
        send_req(make_req(MODE_SET, 32'd201, 32'd4));
        send_req(make_req(MODE_GET, 32'd200, 32'd0));
        send_req(make_req(MODE_GET, 32'd201, 32'd0));

        // Oversized capacity saturates at the array size.
        write_capacity(5'd31);
        send_req(make_req(MODE_SET, 32'd300, 32'd5));
        send_req(make_req(MODE_SET, 32'd301, 32'd6));
        send_req(make_req(MODE_GET, 32'd301, 32'd0));

        for (int p = 0; p < 10; p++)
        begin
            write_capacity(caps[p]);
            steady = (p == 6);
            base   = $urandom;
            pool   = board.effective_capacity() + board.effective_capacity() / 2 + 2;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 3 && n == 10)
                    want_hold = 1'b1;
                send_req(random_req(pool, base));
            end
        end
        steady = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("tb_lru_cache_key_value_store passed");
        else
            $display("tb_lru_cache_key_value_store failed");
        $finish;
    end

endmodule
